### rtl/core/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK_REAR  = 3'd5;

    localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic shift_in;
        logic shift_out;
        logic write_at;
    } lane_ctrl_t;

    typedef struct packed {
        lane_ctrl_t front;
        lane_ctrl_t rear;
    } cell_ctrl_t;

endpackage

### rtl/core/dq_cell.sv
`timescale 1ns / 1ps

module dq_cell
    import dq_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 4
) (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [CNT_W-1:0]  count,
    input  logic [DATA_W-1:0] value,
    input  logic [DATA_W-1:0] front_left,
    input  logic [DATA_W-1:0] front_right,
    input  logic [DATA_W-1:0] rear_left,
    input  logic [DATA_W-1:0] rear_right,
    output logic [DATA_W-1:0] front_q,
    output logic [DATA_W-1:0] rear_q
);

    logic [DATA_W-1:0] front_reg;
    logic [DATA_W-1:0] front_next;
    logic [DATA_W-1:0] rear_reg;
    logic [DATA_W-1:0] rear_next;
    logic              here;

    // this slot is the first free one
    assign here = (count == CNT_W'(INDEX));

    always_comb begin
        priority if (ctrl.front.shift_in) begin
            front_next = front_left;
        end else if (ctrl.front.shift_out) begin
            front_next = front_right;
        end else if (ctrl.front.write_at && here) begin
            front_next = value;
        end else begin
            front_next = front_reg;
        end
    end

    always_comb begin
        priority if (ctrl.rear.shift_in) begin
            rear_next = rear_left;
        end else if (ctrl.rear.shift_out) begin
            rear_next = rear_right;
        end else if (ctrl.rear.write_at && here) begin
            rear_next = value;
        end else begin
            rear_next = rear_reg;
        end
    end

    always_ff @(posedge aclk) begin
        front_reg <= front_next;
        rear_reg  <= rear_next;
    end

    assign front_q = front_reg;
    assign rear_q  = rear_reg;

endmodule

### rtl/core/dq_ctrl.sv
`timescale 1ns / 1ps

module dq_ctrl
    import dq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [CMD_W-1:0]  command,
    input  logic [DATA_W-1:0] front_word,
    input  logic [DATA_W-1:0] rear_word,
    output cell_ctrl_t        ctrl,
    output logic [CNT_W-1:0]  count,
    output logic [STAT_W-1:0] status,
    output logic [DATA_W-1:0] data
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             full;
    logic             empty;
    cell_ctrl_t       op;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb begin
        op         = '0;
        status     = STAT_DONE;
        data       = '0;
        count_next = count_reg;
        unique case (command)
            CMD_PUSH_FRONT: begin
                if (full) begin
                    status = STAT_OVERFLOW;
                end else begin
                    op.front.shift_in = 1'b1;
                    op.rear.write_at  = 1'b1;
                    count_next        = count_reg + CNT_W'(1);
                end
            end
            CMD_PUSH_REAR: begin
                if (full) begin
                    status = STAT_OVERFLOW;
                end else begin
                    op.rear.shift_in  = 1'b1;
                    op.front.write_at = 1'b1;
                    count_next        = count_reg + CNT_W'(1);
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    status = STAT_UNDERFLOW;
                end else begin
                    data               = front_word;
                    op.front.shift_out = 1'b1;
                    count_next         = count_reg - CNT_W'(1);
                end
            end
            CMD_POP_REAR: begin
                if (empty) begin
                    status = STAT_UNDERFLOW;
                end else begin
                    data              = rear_word;
                    op.rear.shift_out = 1'b1;
                    count_next        = count_reg - CNT_W'(1);
                end
            end
            CMD_PEEK_FRONT: begin
                if (empty) begin
                    status = STAT_UNDERFLOW;
                end else begin
                    data = front_word;
                end
            end
            CMD_PEEK_REAR: begin
                if (empty) begin
                    status = STAT_UNDERFLOW;
                end else begin
                    data = rear_word;
                end
            end
            default: begin
            end
        endcase
    end

    assign ctrl  = accept ? op : '0;
    assign count = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count beyond depth");

    a_lane_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctrl.front.shift_in, ctrl.front.shift_out, ctrl.front.write_at})
        && $onehot0({ctrl.rear.shift_in, ctrl.rear.shift_out, ctrl.rear.write_at}))
        else $error("conflicting lane actions");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> count_reg == $past(count_reg))
        else $error("count moved without a transfer");

    a_lanes_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.front.shift_in || ctrl.front.write_at)
        == (ctrl.rear.shift_in || ctrl.rear.write_at))
        else $error("lanes disagree on push");

endmodule

### rtl/core/circular_deque.sv
`timescale 1ns / 1ps

// Double-ended queue of up to DEPTH 32-bit elements. Each input transfer carries a
// command (push front, push rear, pop front, pop rear, peek front, peek rear) and a
// value, and yields exactly one result transfer with a status (done, overflow,
// underflow) and the popped or peeked element. The store is a row of DEPTH cells,
// each holding the element at its distance from the front and the one at its
// distance from the rear, so both ends are always in the first cell; each command
// updates the store as it is accepted, and one command is taken per cycle while
// s_tready is high. Results pass an output register with a skid stage, so input is
// only held off once two results are waiting.

module circular_deque
    import dq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // command[2:0], value[34:3]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // status[1:0], data[33:2]
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic              accept;
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] value;
    cell_ctrl_t        ctrl;
    logic [CNT_W-1:0]  count;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;

    logic [DATA_W-1:0] front_q [DEPTH];
    logic [DATA_W-1:0] rear_q  [DEPTH];

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    logic [M_TDATA_W-1:0] skid_data_reg;
    logic [M_TDATA_W-1:0] skid_data_next;
    logic [M_TDATA_W-1:0] result;
    logic                 take;

    assign command = s_tdata[CMD_W-1:0];
    assign value   = s_tdata[CMD_W+DATA_W-1:CMD_W];
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    dq_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .command    (command),
        .front_word (front_q[0]),
        .rear_word  (rear_q[0]),
        .ctrl       (ctrl),
        .count      (count),
        .status     (status),
        .data       (data)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] front_left;
        logic [DATA_W-1:0] front_right;
        logic [DATA_W-1:0] rear_left;
        logic [DATA_W-1:0] rear_right;

        if (i == 0) begin : g_head
            assign front_left = value;
            assign rear_left  = value;
        end else begin : g_body
            assign front_left = front_q[i-1];
            assign rear_left  = rear_q[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign front_right = '0;
            assign rear_right  = '0;
        end else begin : g_mid
            assign front_right = front_q[i+1];
            assign rear_right  = rear_q[i+1];
        end

        dq_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .count       (count),
            .value       (value),
            .front_left  (front_left),
            .front_right (front_right),
            .rear_left   (rear_left),
            .rear_right  (rear_right),
            .front_q     (front_q[i]),
            .rear_q      (rear_q[i])
        );
    end

    assign result = {{(M_TDATA_W - STAT_W - DATA_W){1'b0}}, data, status};
    assign take   = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || take) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (accept) begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (accept) begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
